@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the RTL top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond holds at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("assertion failed");

// cons holds in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/core/edfq_pkg.sv @@
// Types and codes shared by the EDF ready queue cells and top level
package edfq_pkg;

	typedef enum logic [1:0] {
		OP_RELEASE  = 2'd0,
		OP_DISPATCH = 2'd1,
		OP_TICK     = 2'd2,
		OP_RSVD     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_RELEASED   = 3'd0,
		ST_DROPPED    = 3'd1,
		ST_DISPATCHED = 3'd2,
		ST_EMPTY      = 3'd3,
		ST_TICK       = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} state_t;

	// per-cell control from the top level
	typedef struct packed {
		logic holds;   // cell carries a live entry
		logic load;    // write the released task here
		logic shift;   // take the entry of the next cell
	} cell_ctl_t;

endpackage

@@ rtl/core/edf_ready_queue_dispatcher_top.sv @@
// EDF ready queue: release, tick and empty dispatch strobe done the cycle after start.
// A dispatch sends a search wave down the row of QUEUE_DEPTH cells, one cell per cycle,
// so it holds busy until the wave has left the last cell and then strobes done.
// Release, tick and reserved items can be taken back to back.
// Reset clears the tick counter, the entry count and the control state; slot contents
// are left as they are and read only below the entry count.
`include "assert_macros.svh"

module edf_ready_queue_dispatcher_top import edfq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [7:0]  task_ident,
	input  logic [31:0] relative_deadline,
	output logic        done,
	output logic [2:0]  status,
	output logic [7:0]  chosen_ident,
	output logic [31:0] chosen_deadline,
	output logic [4:0]  entries_held
);

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	state_t          state_q, state_d;
	logic [31:0]     time_q, time_d;
	logic [CW-1:0]   count_q, count_d;
	logic            accept;
	op_t             op;
	logic [31:0]     absd;
	logic            launch;
	logic            rel_write;
	logic            remove;
	logic            res_valid;
	status_t         res_status;
	logic [7:0]      res_ident;
	logic [31:0]     res_dl;

	logic            done_q;
	status_t         status_q;
	logic [7:0]      ident_q;
	logic [31:0]     dl_q;
	logic [4:0]      held_q;

	// search wave, position i feeds cell i
	logic [QUEUE_DEPTH:0] tok;
	logic [31:0]          wdl  [0:QUEUE_DEPTH];
	logic [7:0]           wid  [0:QUEUE_DEPTH];
	logic [IW-1:0]        widx [0:QUEUE_DEPTH];

	logic [7:0]  c_ident [0:QUEUE_DEPTH-1];
	logic [31:0] c_dl    [0:QUEUE_DEPTH-1];

	assign busy   = (state_q == S_SCAN);
	assign accept = start && (state_q == S_IDLE);
	assign op     = op_t'(operation);
	assign absd   = time_q + relative_deadline;

	assign tok[0]  = launch;
	assign wdl[0]  = '0;
	assign wid[0]  = '0;
	assign widx[0] = '0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		cell_ctl_t   ctl;
		logic [7:0]  nxt_id;
		logic [31:0] nxt_dl;

		assign ctl.holds = (count_q > CW'(i));
		assign ctl.load  = rel_write && (count_q == CW'(i));
		assign ctl.shift = remove && (widx[QUEUE_DEPTH] <= IW'(i));

		if (i + 1 < QUEUE_DEPTH) begin : g_mid
			assign nxt_id = c_ident[i+1];
			assign nxt_dl = c_dl[i+1];
		end else begin : g_last
			assign nxt_id = c_ident[i];
			assign nxt_dl = c_dl[i];
		end

		edfq_cell #(
			.IDX_W      (IW),
			.CELL_INDEX (IW'(i))
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.new_ident    (task_ident),
			.new_deadline (absd),
			.nxt_ident    (nxt_id),
			.nxt_deadline (nxt_dl),
			.ident        (c_ident[i]),
			.deadline     (c_dl[i]),
			.tok_in       (tok[i]),
			.dl_in        (wdl[i]),
			.id_in        (wid[i]),
			.idx_in       (widx[i]),
			.tok_out      (tok[i+1]),
			.dl_out       (wdl[i+1]),
			.id_out       (wid[i+1]),
			.idx_out      (widx[i+1])
		);
	end

	always_comb begin
		state_d    = state_q;
		time_d     = time_q;
		count_d    = count_q;
		launch     = 1'b0;
		rel_write  = 1'b0;
		remove     = 1'b0;
		res_valid  = 1'b0;
		res_status = ST_TICK;
		res_ident  = '0;
		res_dl     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (op)
						OP_RELEASE: begin
							res_valid = 1'b1;
							if (count_q == DEPTH_C) begin
								res_status = ST_DROPPED;
							end else begin
								rel_write  = 1'b1;
								count_d    = count_q + CW'(1);
								res_status = ST_RELEASED;
								res_dl     = absd;
							end
						end
						OP_DISPATCH: begin
							if (count_q == '0) begin
								res_valid  = 1'b1;
								res_status = ST_EMPTY;
							end else begin
								launch  = 1'b1;
								state_d = S_SCAN;
							end
						end
						OP_TICK: begin
							time_d    = time_q + 32'd1;
							res_valid = 1'b1;
						end
						OP_RSVD: begin
							res_valid = 1'b1;
						end
					endcase
				end
			end
			S_SCAN: begin
				// wave has left the last cell: drop the winner and close the gap
				if (tok[QUEUE_DEPTH]) begin
					remove     = 1'b1;
					count_d    = count_q - CW'(1);
					res_valid  = 1'b1;
					res_status = ST_DISPATCHED;
					res_ident  = wid[QUEUE_DEPTH];
					res_dl     = wdl[QUEUE_DEPTH];
					state_d    = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			time_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			time_q  <= time_d;
			count_q <= count_d;
			done_q  <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			status_q <= res_status;
			ident_q  <= res_ident;
			dl_q     <= res_dl;
			held_q   <= 5'(count_d);
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign chosen_ident    = ident_q;
	assign chosen_deadline = dl_q;
	assign entries_held    = held_q;

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= DEPTH_C)
	`ASSERT_ALWAYS(a_one_wave, clk, arst_n, $onehot0(tok))
	`ASSERT_IMPLIES(a_wave_in_scan, clk, arst_n, tok[QUEUE_DEPTH], state_q == S_SCAN)
	`ASSERT_IMPLIES(a_dispatch_count, clk, arst_n, done_q && (status_q == ST_DISPATCHED),
		count_q == $past(count_q) - CW'(1))

endmodule

@@ rtl/core/edfq_cell.sv @@
// One queue slot with its stage of the earliest-deadline search wave
module edfq_cell import edfq_pkg::*; #(
	parameter int IDX_W = 4,
	parameter logic [IDX_W-1:0] CELL_INDEX = '0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctl_t        ctl,
	input  logic [7:0]       new_ident,
	input  logic [31:0]      new_deadline,
	input  logic [7:0]       nxt_ident,
	input  logic [31:0]      nxt_deadline,
	output logic [7:0]       ident,
	output logic [31:0]      deadline,
	input  logic             tok_in,
	input  logic [31:0]      dl_in,
	input  logic [7:0]       id_in,
	input  logic [IDX_W-1:0] idx_in,
	output logic             tok_out,
	output logic [31:0]      dl_out,
	output logic [7:0]       id_out,
	output logic [IDX_W-1:0] idx_out
);

	logic [7:0]       ident_q;
	logic [31:0]      deadline_q;
	logic             tok_q;
	logic [31:0]      dl_q;
	logic [7:0]       id_q;
	logic [IDX_W-1:0] idx_q;
	logic             first;
	logic             take;

	assign first = (CELL_INDEX == '0);
	// strict compare keeps the older entry on a tie
	assign take  = ctl.holds && (first || (deadline_q < dl_in));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= tok_in;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in) begin
			if (take) begin
				dl_q  <= deadline_q;
				id_q  <= ident_q;
				idx_q <= CELL_INDEX;
			end else begin
				dl_q  <= dl_in;
				id_q  <= id_in;
				idx_q <= idx_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			ident_q    <= new_ident;
			deadline_q <= new_deadline;
		end else if (ctl.shift) begin
			ident_q    <= nxt_ident;
			deadline_q <= nxt_deadline;
		end
	end

	assign ident    = ident_q;
	assign deadline = deadline_q;
	assign tok_out  = tok_q;
	assign dl_out   = dl_q;
	assign id_out   = id_q;
	assign idx_out  = idx_q;

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the EDF ready queue dispatcher: directed table, then random traffic
`timescale 1ns / 100ps

module tb import edfq_pkg::*;;

	localparam int DEPTH = 16;
	localparam int RANDOM_ITEMS = 1700;
	localparam int PLAN_ROWS = 26;

	typedef struct packed {
		status_t     status;
		logic [7:0]  ident;
		logic [31:0] deadline;
		logic [4:0]  held;
	} sched_result_t;

	typedef struct packed {
		op_t           op;
		logic [7:0]    ident;
		logic [31:0]   rel;
		logic          typed;
		sched_result_t want;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  operation;
	logic [7:0]  task_ident;
	logic [31:0] relative_deadline;
	logic        done;
	logic [2:0]  status;
	logic [7:0]  chosen_ident;
	logic [31:0] chosen_deadline;
	logic [4:0]  entries_held;

	// predictor state
	logic [31:0]   tick_count;
	logic [7:0]    waiting_ident[$];
	logic [31:0]   waiting_deadline[$];
	sched_result_t outcomes_due[$];

	int errors;
	int n_released, n_dropped, n_dispatched, n_empty, n_ticks, peak_held;

	plan_row_t plan [PLAN_ROWS];

	edf_ready_queue_dispatcher_top #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.task_ident(task_ident),
		.relative_deadline(relative_deadline),
		.done(done),
		.status(status),
		.chosen_ident(chosen_ident),
		.chosen_deadline(chosen_deadline),
		.entries_held(entries_held)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Apply one item to the predictor and return what the block should report.
	function automatic sched_result_t edf_outcome(op_t op, logic [7:0] id, logic [31:0] rel);
		sched_result_t r;
		int best;
		r = '{ST_TICK, 8'h00, 32'h0, 5'd0};
		case (op)
			OP_RELEASE: begin
				if (waiting_ident.size() >= DEPTH) begin
					r.status = ST_DROPPED;
					n_dropped++;
				end else begin
					waiting_ident.push_back(id);
					waiting_deadline.push_back(tick_count + rel);
					r.status = ST_RELEASED;
					r.deadline = tick_count + rel;
					n_released++;
				end
			end
			OP_DISPATCH: begin
				if (waiting_ident.size() == 0) begin
					r.status = ST_EMPTY;
					n_empty++;
				end else begin
					// strict less-than keeps the oldest entry on ties
					best = 0;
					for (int i = 1; i < waiting_deadline.size(); i++)
						if (waiting_deadline[i] < waiting_deadline[best])
							best = i;
					r.status = ST_DISPATCHED;
					r.ident = waiting_ident[best];
					r.deadline = waiting_deadline[best];
					waiting_ident.delete(best);
					waiting_deadline.delete(best);
					n_dispatched++;
				end
			end
			OP_TICK: begin
				tick_count = tick_count + 32'd1;
				n_ticks++;
			end
			default: ;
		endcase
		r.held = 5'(waiting_ident.size());
		if (waiting_ident.size() > peak_held)
			peak_held = waiting_ident.size();
		return r;
	endfunction

	// Drive at the falling edge; hold start until the transfer happens.
	task automatic send(op_t op, logic [7:0] id, logic [31:0] rel, logic typed,
		sched_result_t want);
		sched_result_t got;
		start <= 1'b1;
		operation <= op;
		task_ident <= id;
		relative_deadline <= rel;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		got = edf_outcome(op, id, rel);
		outcomes_due.push_back(typed ? want : got);
		@(negedge clk);
	endtask

	// Now and then lower start for a random stretch, with junk on the payload; never in a burst.
	task automatic pause(bit burst);
		int r, n;
		r = $urandom_range(0, 99);
		if (burst || r < 60)
			n = 0;
		else if (r < 90)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(8, 40);
		if (n > 0) begin
			start <= 1'b0;
			operation <= 2'($urandom);
			task_ident <= 8'($urandom);
			relative_deadline <= $urandom;
			repeat (n) @(negedge clk);
		end
	endtask

	function automatic logic [31:0] pick_rel();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 32'($urandom_range(0, 15));
		else if (r < 60)
			return 32'($urandom_range(0, 1000));
		else if (r < 85)
			return $urandom;
		else
			return 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
	endfunction

	always @(posedge clk) begin
		sched_result_t exp_r;
		if (arst_n && done) begin
			if (outcomes_due.size() == 0) begin
				$error("result with nothing expected: status %0d", status);
				errors++;
			end else begin
				exp_r = outcomes_due.pop_front();
				if (status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, status);
					errors++;
				end
				if (chosen_ident !== exp_r.ident) begin
					$error("chosen_ident: expected %0d, got %0d", exp_r.ident, chosen_ident);
					errors++;
				end
				if (chosen_deadline !== exp_r.deadline) begin
					$error("chosen_deadline: expected %0h, got %0h", exp_r.deadline,
						chosen_deadline);
					errors++;
				end
				if (entries_held !== exp_r.held) begin
					$error("entries_held: expected %0d, got %0d", exp_r.held, entries_held);
					errors++;
				end
			end
		end
	end

	initial begin
		int rel_weight, r;
		bit burst;
		op_t op;
		sched_result_t none;

		none = '{ST_TICK, 8'h00, 32'h0, 5'd0};
		errors = 0;
		n_released = 0;
		n_dropped = 0;
		n_dispatched = 0;
		n_empty = 0;
		n_ticks = 0;
		peak_held = 0;
		tick_count = 32'h0;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_TICK;
		task_ident = 8'h00;
		relative_deadline = 32'h0;

		// empty queue, reserved code, first tick, then a deadline that wraps to zero
		plan[0]  = '{OP_DISPATCH, 8'h00, 32'h0, 1'b1, '{ST_EMPTY, 8'h00, 32'h0, 5'd0}};
		plan[1]  = '{OP_RSVD, 8'hFF, 32'hFFFF_FFFF, 1'b1, '{ST_TICK, 8'h00, 32'h0, 5'd0}};
		plan[2]  = '{OP_TICK, 8'h00, 32'h0, 1'b1, '{ST_TICK, 8'h00, 32'h0, 5'd0}};
		plan[3]  = '{OP_RELEASE, 8'hFF, 32'hFFFF_FFFF, 1'b1,
			'{ST_RELEASED, 8'h00, 32'h0, 5'd1}};
		plan[4]  = '{OP_RELEASE, 8'h00, 32'h0, 1'b1, '{ST_RELEASED, 8'h00, 32'h1, 5'd2}};
		plan[5]  = '{OP_RELEASE, 8'hA5, 32'h0, 1'b1, '{ST_RELEASED, 8'h00, 32'h1, 5'd3}};
		// minimum sits in entry zero, then a tie that the oldest wins
		plan[6]  = '{OP_DISPATCH, 8'h00, 32'h0, 1'b1, '{ST_DISPATCHED, 8'hFF, 32'h0, 5'd2}};
		plan[7]  = '{OP_DISPATCH, 8'h00, 32'h0, 1'b1, '{ST_DISPATCHED, 8'h00, 32'h1, 5'd1}};
		// fill to the top
		plan[8]  = '{OP_RELEASE, 8'h01, 32'hFFFF_FFFE, 1'b0, none};
		plan[9]  = '{OP_RELEASE, 8'h02, 32'h8000_0000, 1'b0, none};
		plan[10] = '{OP_RELEASE, 8'h04, 32'h5, 1'b0, none};
		plan[11] = '{OP_RELEASE, 8'h08, 32'h5, 1'b0, none};
		plan[12] = '{OP_RELEASE, 8'h10, 32'h7FFF_FFFF, 1'b0, none};
		plan[13] = '{OP_RELEASE, 8'h20, 32'h3, 1'b0, none};
		plan[14] = '{OP_RELEASE, 8'h40, 32'h5555_5555, 1'b0, none};
		plan[15] = '{OP_RELEASE, 8'h80, 32'hAAAA_AAAA, 1'b0, none};
		plan[16] = '{OP_RELEASE, 8'h7E, 32'h0, 1'b0, none};
		plan[17] = '{OP_RELEASE, 8'h5A, 32'h3, 1'b0, none};
		plan[18] = '{OP_RELEASE, 8'hC3, 32'h1234_5678, 1'b0, none};
		plan[19] = '{OP_RELEASE, 8'h3C, 32'hFFFF_0000, 1'b0, none};
		plan[20] = '{OP_RELEASE, 8'h99, 32'h0000_FFFF, 1'b0, none};
		plan[21] = '{OP_RELEASE, 8'h66, 32'h1, 1'b0, none};
		plan[22] = '{OP_RELEASE, 8'hE7, 32'h0, 1'b0, none};
		plan[23] = '{OP_RELEASE, 8'h3C, 32'h7, 1'b1, '{ST_DROPPED, 8'h00, 32'h0, 5'd16}};
		plan[24] = '{OP_DISPATCH, 8'h00, 32'h0, 1'b0, none};
		plan[25] = '{OP_TICK, 8'h00, 32'h0, 1'b1, '{ST_TICK, 8'h00, 32'h0, 5'd15}};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		for (int i = 0; i < PLAN_ROWS; i++) begin
			send(plan[i].op, plan[i].ident, plan[i].rel, plan[i].typed, plan[i].want);
			pause(1'b0);
		end

		rel_weight = 50;
		burst = 1'b0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// shift the mix now and then so the queue swings between empty and full
			if (i % 64 == 0) begin
				r = $urandom_range(0, 2);
				rel_weight = (r == 0) ? 20 : (r == 1) ? 50 : 80;
				burst = ($urandom_range(0, 3) == 0);
			end
			r = $urandom_range(0, 99);
			if (r < rel_weight)
				op = OP_RELEASE;
			else if (r < rel_weight + (100 - rel_weight) * 70 / 100)
				op = OP_DISPATCH;
			else if (r < 97)
				op = OP_TICK;
			else
				op = OP_RSVD;
			send(op, 8'($urandom), pick_rel(), 1'b0, none);
			pause(burst);
		end

		start <= 1'b0;
		while (outcomes_due.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 4) @(posedge clk);

		$display("Ran %0d items: %0d released, %0d dropped, %0d dispatched, %0d empty, %0d ticks",
			PLAN_ROWS + RANDOM_ITEMS, n_released, n_dropped, n_dispatched, n_empty, n_ticks);
		$display("Deepest queue seen: %0d of %0d entries", peak_held, DEPTH);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
